@@ sv/wshr_pkg.sv @@
// ----------------------------------------------------------------------------
// wshr_pkg: shared types for the weighted stress Hessian row streamer
// Operation codes and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wshr_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SELF,
		OP_PREP,
		OP_DSTEP,
		OP_DNEXT,
		OP_MAC,
		OP_TERM,
		OP_PAIR,
		OP_DIAG
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] mac_idx;
	} cmd_t;

	typedef struct packed {
		logic self_pair;
		logic row_end;
		logic zero_dist;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

@@ sv/weighted_stress_hessian_row.sv @@
// ----------------------------------------------------------------------------
// weighted_stress_hessian_row: streams one Hessian block row
// Emits the negated weighted stress term per pair (plus V-B on a diagonal
// block) and the row's diagonal entry after the last pair.
//
//   channel  signals                         direction
//   in       in_valid/in_stall + pair fields  input word
//   out      out_valid/out_stall + result     output word
//
// A pair word's run time is set by the serial restoring divider (one
// quotient bit a cycle, three divides); zero distance and self pair words
// skip the divides and may wait on the output.
// Reset clears the controller, the row sum and the diagonal correction.
// A stalled output holds the result; the next word computes meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_stress_hessian_row import wshr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [30:0] weight,
	input  wire logic        [30:0] dissimilarity,
	input  wire logic        [30:0] distance,
	input  wire logic signed [31:0] diff_dim_s,
	input  wire logic signed [31:0] diff_dim_t,
	input  wire logic signed [31:0] v_entry,
	input  wire logic signed [31:0] b_entry,
	input  wire logic               diag_block,
	input  wire logic               self_pair,
	input  wire logic               row_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] value,
	output logic                    on_diagonal,
	output logic                    zero_distance,
	output logic                    last
);

	cmd_t    cmd;
	status_t status;

	wshr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	wshr_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.weight        (weight),
		.dissimilarity (dissimilarity),
		.distance      (distance),
		.diff_dim_s    (diff_dim_s),
		.diff_dim_t    (diff_dim_t),
		.v_entry       (v_entry),
		.b_entry       (b_entry),
		.diag_block    (diag_block),
		.self_pair     (self_pair),
		.row_end       (row_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.on_diagonal   (on_diagonal),
		.zero_distance (zero_distance),
		.last          (last)
	);

endmodule

`default_nettype wire

@@ sv/wshr_ctrl.sv @@
// ----------------------------------------------------------------------------
// wshr_ctrl: sequencer for one pair word
// Steps the datapath through capture, three serial divides, the partial
// product accumulation and the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module wshr_ctrl import wshr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	localparam int DW    = 62 + FRAC_BITS;
	localparam int CNT_W = $clog2(DW + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_SELF,
		S_PREP,
		S_DIV,
		S_DNEXT,
		S_MAC,
		S_TERM,
		S_PAIR,
		S_DIAG
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       div_idx_q;
	logic [1:0]       mac_q;

	assign in_stall = (state_q != S_IDLE);

	// command decode from state
	always_comb begin
		cmd.mac_idx = mac_q;
		case (state_q)
			S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			S_SELF:  cmd.op = OP_SELF;
			S_PREP:  cmd.op = OP_PREP;
			S_DIV:   cmd.op = OP_DSTEP;
			S_DNEXT: cmd.op = OP_DNEXT;
			S_MAC:   cmd.op = OP_MAC;
			S_TERM:  cmd.op = OP_TERM;
			S_PAIR:  cmd.op = status.out_free ? OP_PAIR : OP_NONE;
			S_DIAG:  cmd.op = status.out_free ? OP_DIAG : OP_NONE;
			default: cmd.op = OP_NONE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			div_idx_q <= '0;
			mac_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DISP;
				end
				S_DISP: begin
					if (status.self_pair) state_q <= S_SELF;
					else if (status.zero_dist) state_q <= S_TERM;
					else state_q <= S_PREP;
				end
				S_SELF: begin
					state_q <= status.row_end ? S_DIAG : S_IDLE;
				end
				S_PREP: begin
					cnt_q     <= '0;
					div_idx_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) state_q <= S_DNEXT;
				end
				S_DNEXT: begin
					cnt_q <= '0;
					mac_q <= '0;
					if (div_idx_q == 2'd2) begin
						state_q <= S_MAC;
					end else begin
						div_idx_q <= div_idx_q + 1'b1;
						state_q   <= S_DIV;
					end
				end
				S_MAC: begin
					mac_q <= mac_q + 1'b1;
					if (mac_q == 2'd3) state_q <= S_TERM;
				end
				S_TERM: begin
					state_q <= S_PAIR;
				end
				S_PAIR: begin
					if (status.out_free) state_q <= status.row_end ? S_DIAG : S_IDLE;
				end
				S_DIAG: begin
					if (status.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/wshr_datapath.sv @@
// ----------------------------------------------------------------------------
// wshr_datapath: arithmetic and row state
// Serial restoring divider, 32x32 partial product accumulator, term
// saturation, row sum and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module wshr_datapath import wshr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output status_t                 status,
	input  wire logic        [30:0] weight,
	input  wire logic        [30:0] dissimilarity,
	input  wire logic        [30:0] distance,
	input  wire logic signed [31:0] diff_dim_s,
	input  wire logic signed [31:0] diff_dim_t,
	input  wire logic signed [31:0] v_entry,
	input  wire logic signed [31:0] b_entry,
	input  wire logic               diag_block,
	input  wire logic               self_pair,
	input  wire logic               row_end,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed      [31:0] value,
	output logic                    on_diagonal,
	output logic                    zero_distance,
	output logic                    last
);

	localparam int DW    = 62 + FRAC_BITS;
	localparam int TWO_F = 2 * FRAC_BITS;
	localparam int ACC_W = 126;
	localparam logic [61:0] QCAP = {62{1'b1}};
	localparam logic [46:0] TMAG_MAX = {47{1'b1}};
	localparam logic signed [47:0] RS_MAX = {1'b0, {47{1'b1}}};
	localparam logic signed [47:0] RS_MIN = {1'b1, {47{1'b0}}};

	// captured word
	logic        [30:0] w_q, dl_q, d_q;
	logic signed [31:0] xs_q, xt_q;
	logic signed [32:0] vb_q;
	logic               diag_q, self_q, end_q;

	// divider and multiplier state
	logic [DW-1:0]    num_q, quo_q;
	logic [31:0]      rem_q;
	logic [61:0]      f_q;
	logic             sat_q;
	logic [62:0]      p_q;
	logic             neg_q;
	logic [ACC_W-1:0] acc_q;

	// row state
	logic signed [47:0] term_q;
	logic signed [47:0] row_sum_q;
	logic signed [32:0] diag_corr_q;

	logic out_valid_q;

	function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
		if (x > 50'sd2147483647) return 32'sh7FFFFFFF;
		if (x < -50'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	assign status.self_pair = self_q;
	assign status.row_end   = end_q;
	assign status.zero_dist = (d_q == 31'd0);
	assign status.out_free  = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;

	// divider step
	logic [31:0] rem_sh, rem_sub;
	logic        rem_ge;
	logic [61:0] quo_cap;
	logic        quo_big;
	always_comb begin
		rem_sh  = {rem_q[30:0], num_q[DW-1]};
		rem_ge  = rem_sh >= {1'b0, d_q};
		rem_sub = rem_sh - {1'b0, d_q};
		quo_big = |quo_q[DW-1:62];
		quo_cap = quo_big ? QCAP : quo_q[61:0];
	end

	// partial product select
	logic [31:0]      pa, pb;
	logic [63:0]      pp;
	logic [ACC_W-1:0] pp_sh;
	always_comb begin
		pa = cmd.mac_idx[0] ? {2'b00, f_q[61:32]} : f_q[31:0];
		pb = cmd.mac_idx[1] ? {1'b0, p_q[62:32]} : p_q[31:0];
		pp = pa * pb;
		pp_sh = {{(ACC_W-64){1'b0}}, pp} << (32 * (32'(cmd.mac_idx[0]) + 32'(cmd.mac_idx[1])));
	end

	// term magnitude from accumulated product
	logic [ACC_W-1:0] acc_shr;
	logic [46:0]      tmag;
	always_comb begin
		acc_shr = acc_q >> TWO_F;
		tmag = (sat_q || (|acc_shr[ACC_W-1:47])) ? TMAG_MAX : acc_shr[46:0];
	end

	// emitted sums
	logic signed [49:0] pair_val, diag_val;
	logic signed [48:0] rs_next;
	always_comb begin
		pair_val = -50'(term_q) + (diag_q ? 50'(vb_q) : 50'sd0);
		diag_val = 50'(row_sum_q) + 50'(diag_corr_q);
		rs_next  = 49'(row_sum_q) + 49'(term_q);
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				w_q    <= weight;
				dl_q   <= dissimilarity;
				d_q    <= distance;
				xs_q   <= diff_dim_s;
				xt_q   <= diff_dim_t;
				vb_q   <= 33'(v_entry) - 33'(b_entry);
				diag_q <= diag_block;
				self_q <= self_pair;
				end_q  <= row_end;
			end
			OP_PREP: begin
				p_q   <= 63'(mag32(xs_q) * mag32(xt_q));
				neg_q <= xs_q[31] ^ xt_q[31];
				num_q <= DW'(w_q * dl_q);
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
			end
			OP_DSTEP: begin
				num_q <= num_q << 1;
				rem_q <= rem_ge ? rem_sub : rem_sh;
				quo_q <= {quo_q[DW-2:0], rem_ge};
			end
			OP_DNEXT: begin
				f_q   <= quo_cap;
				sat_q <= sat_q | quo_big;
				num_q <= {quo_cap, {FRAC_BITS{1'b0}}};
				rem_q <= '0;
				quo_q <= '0;
				acc_q <= '0;
			end
			OP_MAC: begin
				acc_q <= acc_q + pp_sh;
			end
			OP_TERM: begin
				if (status.zero_dist || p_q == 63'd0) term_q <= '0;
				else if (neg_q) term_q <= -$signed({1'b0, tmag});
				else term_q <= $signed({1'b0, tmag});
			end
			default: ;
		endcase
	end

	// row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_sum_q   <= '0;
			diag_corr_q <= '0;
		end else begin
			case (cmd.op)
				OP_SELF: begin
					if (diag_q) diag_corr_q <= vb_q;
				end
				OP_PAIR: begin
					if (rs_next > 49'(RS_MAX)) row_sum_q <= RS_MAX;
					else if (rs_next < 49'(RS_MIN)) row_sum_q <= RS_MIN;
					else row_sum_q <= rs_next[47:0];
				end
				OP_DIAG: begin
					row_sum_q   <= '0;
					diag_corr_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_PAIR || cmd.op == OP_DIAG) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PAIR) begin
			value         <= sat32(pair_val);
			on_diagonal   <= 1'b0;
			zero_distance <= status.zero_dist;
			last          <= 1'b0;
		end else if (cmd.op == OP_DIAG) begin
			value         <= sat32(diag_val);
			on_diagonal   <= 1'b1;
			zero_distance <= 1'b0;
			last          <= 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ tb/weighted_stress_hessian_row_test.sv @@
// ----------------------------------------------------------------------------
// weighted_stress_hessian_row_test: self-checking bench for the Hessian row
// A table of directed pair words runs first. Random rows follow: pair words
// with random content and one optional self pair, mixed with noise words.
// Each accepted word is run through a local fixed point predictor. Every
// result word is compared field by field with the oldest expected entry.
// Sender idling and receiver stall change from phase to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_stress_hessian_row_test import wshr_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint TERM_MAX = 64'sh7FFF_FFFF_FFFF;
	localparam longint TERM_MIN = -TERM_MAX - 1;
	localparam logic [127:0] QCAP = 128'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [30:0] U31_MAX = 31'h7FFF_FFFF;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [30:0]        weight;
		logic [30:0]        dissim;
		logic [30:0]        dval;
		logic signed [31:0] ds;
		logic signed [31:0] dt;
		logic signed [31:0] v;
		logic signed [31:0] b;
		logic               diag;
		logic               self_p;
		logic               rend;
	} pair_word_t;

	typedef struct {
		logic signed [31:0] value;
		logic               on_diag;
		logic               zd;
		logic               last;
	} hess_entry_t;

	typedef struct {
		pair_word_t  word;
		logic        known;
		hess_entry_t entry;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [30:0] weight = '0;
	logic [30:0] dissimilarity = '0;
	logic [30:0] distance = '0;
	logic signed [31:0] diff_dim_s = '0;
	logic signed [31:0] diff_dim_t = '0;
	logic signed [31:0] v_entry = '0;
	logic signed [31:0] b_entry = '0;
	logic diag_block = 1'b0;
	logic self_pair = 1'b0;
	logic row_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] value;
	logic on_diagonal;
	logic zero_distance;
	logic last;

	weighted_stress_hessian_row DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.weight(weight), .dissimilarity(dissimilarity), .distance(distance),
		.diff_dim_s(diff_dim_s), .diff_dim_t(diff_dim_t),
		.v_entry(v_entry), .b_entry(b_entry),
		.diag_block(diag_block), .self_pair(self_pair), .row_end(row_end),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .on_diagonal(on_diagonal),
		.zero_distance(zero_distance), .last(last)
	);

	always #5 clk = ~clk;

	hess_entry_t entry_q[$];
	longint row_sum_acc = 0;
	longint diag_corr = 0;
	int err_cnt = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int quiet_cycles = 0;

	// w*delta/d^3 * dx_s * dx_t in raw Q form, saturated to 48 bits
	function automatic longint stress_term(pair_word_t p);
		logic [127:0] f1, f2, f3, prod;
		logic [63:0] mag_s, mag_t, dprod;
		logic capped;
		longint mag;
		capped = 1'b0;
		f1 = (128'(p.weight) * 128'(p.dissim)) / 128'(p.dval);
		f2 = (f1 << FRAC) / 128'(p.dval);
		if (f2 > QCAP) begin
			f2 = QCAP;
			capped = 1'b1;
		end
		f3 = (f2 << FRAC) / 128'(p.dval);
		if (f3 > QCAP) begin
			f3 = QCAP;
			capped = 1'b1;
		end
		mag_s = (p.ds < 0) ? -longint'(p.ds) : longint'(p.ds);
		mag_t = (p.dt < 0) ? -longint'(p.dt) : longint'(p.dt);
		dprod = mag_s * mag_t;
		if (dprod == 0)
			return 0;
		if (capped) begin
			mag = TERM_MAX;
		end else begin
			prod = (f3 * 128'(dprod)) >> (2 * FRAC);
			mag = (prod > 128'(TERM_MAX)) ? TERM_MAX : longint'(prod[63:0]);
		end
		return ((p.ds < 0) != (p.dt < 0)) ? -mag : mag;
	endfunction

	function automatic logic signed [31:0] clamp32(longint x);
		if (x > longint'(S32_MAX))
			return S32_MAX;
		if (x < longint'(S32_MIN))
			return S32_MIN;
		return x[31:0];
	endfunction

	// update row state and queue the result words of one accepted pair word
	task automatic predict_row_entries(pair_word_t p, logic known, hess_entry_t kent);
		longint term, vb;
		hess_entry_t e;
		vb = longint'(p.v) - longint'(p.b);
		if (p.self_p) begin
			if (p.diag)
				diag_corr = vb;
		end else begin
			term = (p.dval == 0) ? 0 : stress_term(p);
			e.value = clamp32(-term + (p.diag ? vb : 0));
			e.on_diag = 1'b0;
			e.zd = (p.dval == 0);
			e.last = 1'b0;
			entry_q.push_back(known ? kent : e);
			known = 1'b0;
			row_sum_acc += term;
			if (row_sum_acc > TERM_MAX)
				row_sum_acc = TERM_MAX;
			if (row_sum_acc < TERM_MIN)
				row_sum_acc = TERM_MIN;
		end
		if (p.rend) begin
			e.value = clamp32(row_sum_acc + diag_corr);
			e.on_diag = 1'b1;
			e.zd = 1'b0;
			e.last = 1'b1;
			entry_q.push_back(known ? kent : e);
			row_sum_acc = 0;
			diag_corr = 0;
		end
	endtask

	// drive one word, with random idle cycles ahead of it; returns after acceptance
	task automatic send_word(pair_word_t p, logic known, hess_entry_t kent);
		logic go;
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		weight <= p.weight;
		dissimilarity <= p.dissim;
		distance <= p.dval;
		diff_dim_s <= p.ds;
		diff_dim_t <= p.dt;
		v_entry <= p.v;
		b_entry <= p.b;
		diag_block <= p.diag;
		self_pair <= p.self_p;
		row_end <= p.rend;
		do begin
			@(negedge clk);
			go = !in_stall;
			@(posedge clk);
		end while (!go);
		predict_row_entries(p, known, kent);
	endtask

	function automatic logic [31:0] rnd_mag();
		return $urandom >> $urandom_range(31);
	endfunction

	function automatic logic signed [31:0] rnd_signed();
		logic signed [31:0] m;
		m = rnd_mag();
		return ($urandom_range(1) == 1) ? -m : m;
	endfunction

	function automatic pair_word_t rnd_word();
		pair_word_t p;
		p.weight = 31'(rnd_mag());
		p.dissim = 31'(rnd_mag());
		p.dval = ($urandom_range(99) < 6) ? 31'd0 : 31'(rnd_mag());
		p.ds = ($urandom_range(99) < 4) ? 32'sd0 : rnd_signed();
		p.dt = rnd_signed();
		p.v = rnd_signed();
		p.b = rnd_signed();
		p.diag = 1'($urandom_range(1));
		p.self_p = 1'($urandom_range(1));
		p.rend = 1'($urandom_range(1));
		return p;
	endfunction

	// mostly well formed rows, some noise words
	task automatic run_random(int n_words);
		int sent, len, self_at;
		logic diag;
		pair_word_t p;
		hess_entry_t none;
		sent = 0;
		none = '{default: '0};
		while (sent < n_words) begin
			if ($urandom_range(99) < 12) begin
				send_word(rnd_word(), 1'b0, none);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				self_at = $urandom_range(len);
				diag = 1'($urandom_range(1));
				for (int k = 0; k < len; k++) begin
					p = rnd_word();
					p.diag = diag;
					p.self_p = (k == self_at);
					p.rend = (k == len - 1);
					send_word(p, 1'b0, none);
					sent++;
				end
			end
		end
	endtask

	// wait until every result word is back, then let the datapath settle
	task automatic drain();
		in_valid <= 1'b0;
		wait (entry_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < rcv_stall_pct);

	// result check; values are stable at the falling edge before acceptance
	always @(negedge clk) begin
		hess_entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (entry_q.size() == 0) begin
				$error("unexpected result word: value %0d", value);
				err_cnt++;
			end else begin
				e = entry_q.pop_front();
				if (value !== e.value) begin
					$error("value: expected %0d, got %0d", e.value, value);
					err_cnt++;
				end
				if (on_diagonal !== e.on_diag) begin
					$error("on_diagonal: expected %0b, got %0b", e.on_diag, on_diagonal);
					err_cnt++;
				end
				if (zero_distance !== e.zd) begin
					$error("zero_distance: expected %0b, got %0b", e.zd, zero_distance);
					err_cnt++;
				end
				if (last !== e.last) begin
					$error("last: expected %0b, got %0b", e.last, last);
					err_cnt++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving on either side
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	dir_row_t dir_rows[$];

	initial begin
		hess_entry_t none;
		none = '{default: '0};
		// self pair ending an empty row: diagonal entry of zero
		dir_rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 1, 1, 1}, 1, '{0, 1, 0, 1}});
		// zero distance, off-diagonal block
		dir_rows.push_back('{'{U31_MAX, U31_MAX, 0, S32_MAX, S32_MIN, 7, 1, 0, 0, 0},
			1, '{0, 0, 1, 0}});
		// zero distance, diagonal block: V-B only, the widest V-B saturates
		dir_rows.push_back('{'{1, 1, 0, 1, 1, 5, 3, 1, 0, 0}, 1, '{2, 0, 1, 0}});
		dir_rows.push_back('{'{0, 0, 0, 0, 0, S32_MAX, S32_MIN, 1, 0, 1}, 1,
			'{S32_MAX, 0, 1, 0}});
		// self pair with extreme V-B, then unit pair and a capped quotient
		dir_rows.push_back('{'{0, 0, 0, 0, 0, S32_MAX, S32_MIN, 1, 1, 0}, 0, none});
		dir_rows.push_back('{'{Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 1, 0, 0}, 0, none});
		dir_rows.push_back('{'{U31_MAX, U31_MAX, 1, S32_MIN, S32_MAX, S32_MIN, S32_MAX, 1, 0, 1},
			0, none});
		// zero weight with zero differences, zero dissimilarity, all widest; widest distance
		dir_rows.push_back('{'{0, U31_MAX, U31_MAX, 0, 0, S32_MIN, S32_MAX, 0, 0, 0}, 0, none});
		dir_rows.push_back('{'{U31_MAX, 0, U31_MAX, S32_MAX, S32_MAX, 0, 0, 0, 0, 0}, 0, none});
		dir_rows.push_back('{'{U31_MAX, U31_MAX, U31_MAX, S32_MAX, S32_MIN, 0, 0, 0, 0, 1},
			0, none});
		// row sum saturating upward, self pair on an off-diagonal block
		for (int k = 0; k < 3; k++)
			dir_rows.push_back('{'{U31_MAX, U31_MAX, 1, S32_MAX, S32_MAX, 0, 0, 0, 0, 0},
				0, none});
		dir_rows.push_back('{'{0, 0, 0, 0, 0, 9, 2, 0, 1, 1}, 0, none});
		// row sum saturating upward with both differences negative, two self pairs, row ending on a self pair
		dir_rows.push_back('{'{0, 0, 0, 0, 0, 100, 1, 1, 1, 0}, 0, none});
		for (int k = 0; k < 3; k++)
			dir_rows.push_back('{'{U31_MAX, U31_MAX, 1, S32_MIN, S32_MIN, 0, 0, 1, 0, 0},
				0, none});
		dir_rows.push_back('{'{0, 0, 0, 0, 0, S32_MIN, S32_MAX, 1, 1, 1}, 0, none});
		// mid-size values without capping
		dir_rows.push_back('{'{3 * Q_ONE, 2 * Q_ONE, 4 * Q_ONE, -Q_ONE, 5 * Q_ONE, 0, 0, 1, 0, 1},
			0, none});

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_word(dir_rows[k].word, dir_rows[k].known, dir_rows[k].entry);
		drain();

		run_random(200);
		drain();
		snd_idle_pct = 61;
		run_random(200);
		drain();
		snd_idle_pct = 0;
		rcv_stall_pct = 61;
		run_random(200);
		drain();
		snd_idle_pct = 8;
		rcv_stall_pct = 8;
		run_random(200);
		drain();

		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
